[hdl/clp_pkg.sv]
// ----------------------------------------------------------------------------
// clp_pkg
// Shared types and field widths of the circular list with play cursor.
// ----------------------------------------------------------------------------
package clp_pkg;

  localparam int CMD_BITS       = 2;
  localparam int KEY_FIELD_BITS = 32;
  localparam int STATUS_BITS    = 2;
  localparam int COUNT_BITS     = 7;
  localparam int IN_TDATA_BITS  = 40;
  localparam int OUT_TDATA_BITS = 48;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_PLAY   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_DONE      = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    status_t                   status;
    logic [KEY_FIELD_BITS-1:0] played_key;
    logic [COUNT_BITS-1:0]     entry_count;
  } result_t;

endpackage

[hdl/clp_store.sv]
// ----------------------------------------------------------------------------
// clp_store
// Key and link memories: one write port each, one shared registered read.
// ----------------------------------------------------------------------------
module clp_store #(
  parameter int DEPTH = 64,
  parameter int KW    = 32,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [KW-1:0] rd_key,
  output logic [AW-1:0] rd_link,
  input  logic          key_we,
  input  logic [AW-1:0] key_waddr,
  input  logic [KW-1:0] key_wdata,
  input  logic          link_we,
  input  logic [AW-1:0] link_waddr,
  input  logic [AW-1:0] link_wdata
);

  logic [KW-1:0] key_mem  [DEPTH];
  logic [AW-1:0] link_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    rd_link <= link_mem[rd_addr];
  end

endmodule

[hdl/clp_ctrl.sv]
// ----------------------------------------------------------------------------
// clp_ctrl
// Command sequencer: allocates slots, walks the list through the shared
// memory read and key compare, and keeps head, tail, cursor and counts.
// ----------------------------------------------------------------------------
module clp_ctrl #(
  parameter int DEPTH = 64,
  parameter int KW    = 32,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             in_ready,
  input  clp_pkg::cmd_t    cmd,
  input  logic [KW-1:0]    key,
  output logic [AW-1:0]    rd_addr,
  input  logic [KW-1:0]    rd_key,
  input  logic [AW-1:0]    rd_link,
  output logic             key_we,
  output logic [AW-1:0]    key_waddr,
  output logic [KW-1:0]    key_wdata,
  output logic             link_we,
  output logic [AW-1:0]    link_waddr,
  output logic [AW-1:0]    link_wdata,
  output logic             res_valid,
  output clp_pkg::result_t res,
  input  logic             res_take
);

  import clp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A_POP,
    ST_A_WRITE,
    ST_A_LINK,
    ST_R_CMP,
    ST_R_FREE,
    ST_P_READ,
    ST_OUT
  } state_t;

  state_t        state;
  logic [KW-1:0] key_reg;
  logic [AW-1:0] slot;
  logic [AW-1:0] cur;
  logic [AW-1:0] prev;
  logic [CW-1:0] walk_idx;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] cursor;
  logic [CW-1:0] count;
  logic [CW-1:0] hwm;
  logic [AW-1:0] free_head;
  status_t       res_status;
  logic [KW-1:0] res_played;

  logic hit;
  assign hit = (rd_key == key_reg);

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_OUT);
  assign res.status      = res_status;
  assign res.played_key  = KEY_FIELD_BITS'(res_played);
  assign res.entry_count = COUNT_BITS'(count);

  always_comb begin
    rd_addr = cur;
    case (state)
      ST_IDLE: begin
        if (cmd == CMD_REMOVE) begin
          rd_addr = head;
        end else if (cmd == CMD_PLAY) begin
          rd_addr = cursor;
        end else begin
          rd_addr = free_head;
        end
      end
      ST_R_CMP: rd_addr = rd_link;
      default:  rd_addr = cur;
    endcase
  end

  always_comb begin
    key_we     = 1'b0;
    key_waddr  = slot;
    key_wdata  = key_reg;
    link_we    = 1'b0;
    link_waddr = slot;
    link_wdata = head;
    case (state)
      ST_A_WRITE: begin
        key_we     = 1'b1;
        link_we    = 1'b1;
        link_waddr = slot;
        link_wdata = (count == '0) ? slot : head;
      end
      ST_A_LINK: begin
        link_we    = 1'b1;
        link_waddr = tail;
        link_wdata = slot;
      end
      ST_R_CMP: begin
        if (hit && count != CW'(1)) begin
          link_we = 1'b1;
          if (walk_idx == '0) begin
            link_waddr = tail;
            link_wdata = rd_link;
          end else if (cur == tail) begin
            link_waddr = prev;
            link_wdata = head;
          end else begin
            link_waddr = prev;
            link_wdata = rd_link;
          end
        end
      end
      ST_R_FREE: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = free_head;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      hwm    <= '0;
      head   <= '0;
      tail   <= '0;
      cursor <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            key_reg    <= key;
            res_played <= '0;
            res_status <= STAT_DONE;
            case (cmd)
              CMD_APPEND: begin
                if (count == CW'(DEPTH)) begin
                  res_status <= STAT_FULL;
                  state      <= ST_OUT;
                end else if (hwm == count) begin
                  slot  <= hwm[AW-1:0];
                  hwm   <= hwm + CW'(1);
                  state <= ST_A_WRITE;
                end else begin
                  slot  <= free_head;
                  state <= ST_A_POP;
                end
              end
              CMD_REMOVE: begin
                if (count == '0) begin
                  res_status <= STAT_EMPTY;
                  state      <= ST_OUT;
                end else begin
                  cur      <= head;
                  prev     <= head;
                  walk_idx <= '0;
                  state    <= ST_R_CMP;
                end
              end
              CMD_PLAY: begin
                if (count == '0) begin
                  res_status <= STAT_EMPTY;
                  state      <= ST_OUT;
                end else begin
                  state <= ST_P_READ;
                end
              end
              default: begin
                state <= ST_OUT;
              end
            endcase
          end
        end
        ST_A_POP: begin
          free_head <= rd_link;
          state     <= ST_A_WRITE;
        end
        ST_A_WRITE: begin
          if (count == '0) begin
            head   <= slot;
            tail   <= slot;
            cursor <= slot;
            count  <= CW'(1);
            state  <= ST_OUT;
          end else begin
            state <= ST_A_LINK;
          end
        end
        ST_A_LINK: begin
          tail  <= slot;
          count <= count + CW'(1);
          state <= ST_OUT;
        end
        ST_R_CMP: begin
          if (hit) begin
            if (count != CW'(1)) begin
              if (walk_idx == '0) begin
                head <= rd_link;
              end else if (cur == tail) begin
                tail <= prev;
              end
            end
            if (cur == cursor) begin
              cursor <= rd_link;
            end
            state <= ST_R_FREE;
          end else if (walk_idx + CW'(1) == count) begin
            res_status <= STAT_NOT_FOUND;
            state      <= ST_OUT;
          end else begin
            prev     <= cur;
            cur      <= rd_link;
            walk_idx <= walk_idx + CW'(1);
          end
        end
        ST_R_FREE: begin
          free_head <= cur;
          count     <= count - CW'(1);
          state     <= ST_OUT;
        end
        ST_P_READ: begin
          res_played <= rd_key;
          cursor     <= rd_link;
          state      <= ST_OUT;
        end
        ST_OUT: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_hwm_covers_count: assert property (@(posedge clk) disable iff (rst)
    hwm >= count)
    else $error("high-water mark below entry count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == STAT_FULL) |-> (count == CW'(DEPTH)))
    else $error("full reported with free slots");

  a_remove_drops_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_R_FREE) |=> (count == $past(count) - CW'(1)))
    else $error("remove did not drop exactly one entry");
`endif

endmodule

[hdl/circular_list_with_play_cursor.sv]
// ----------------------------------------------------------------------------
// circular_list_with_play_cursor
// Circular list of keys with append, remove-first-match and a play cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_ channel, one item per command; each command
//   gives exactly one result item on the m_ channel (status, played key,
//   entry count after the command).
//   The remove walk reads one entry per cycle from the key/link memory
//   and tests it on the one key comparator; that walk sets the
//   worst-case rate. s_tready is high only while no command is in work.
//   Freed slots go on a free stack threaded through the link memory, and
//   never-used slots are taken from a high-water mark, so reset needs no
//   clearing pass: after rst the list is empty and a command may enter in
//   the next cycle.
//   The result waits in an output register while m_tready is low; one more
//   command may be taken and worked meanwhile, and its result holds in the
//   sequencer until the output register frees.
// ----------------------------------------------------------------------------
module circular_list_with_play_cursor #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // command[1:0], song_key[33:2], zero pad
  input  logic [clp_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // status[1:0], played_key[33:2], entry_count[40:34], zero pad
  output logic [clp_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);

  import clp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (KEY_BITS < KEY_FIELD_BITS) ? KEY_BITS : KEY_FIELD_BITS;
  localparam int PAD_BITS = OUT_TDATA_BITS - STATUS_BITS - KEY_FIELD_BITS - COUNT_BITS;

  logic                      start;
  cmd_t                      cmd;
  logic [KEY_FIELD_BITS-1:0] song_key;
  logic [AW-1:0]             rd_addr;
  logic [KW-1:0]             rd_key;
  logic [AW-1:0]             rd_link;
  logic                      key_we;
  logic [AW-1:0]             key_waddr;
  logic [KW-1:0]             key_wdata;
  logic                      link_we;
  logic [AW-1:0]             link_waddr;
  logic [AW-1:0]             link_wdata;
  logic                      res_valid;
  result_t                   res;
  logic                      res_take;

  assign start    = s_tvalid && s_tready;
  assign cmd      = cmd_t'(s_tdata[CMD_BITS-1:0]);
  assign song_key = s_tdata[CMD_BITS +: KEY_FIELD_BITS];
  assign res_take = !m_tvalid || m_tready;

  clp_store #(
    .DEPTH (DEPTH),
    .KW    (KW),
    .AW    (AW)
  ) u_store (
    .clk        (clk),
    .rd_addr    (rd_addr),
    .rd_key     (rd_key),
    .rd_link    (rd_link),
    .key_we     (key_we),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata)
  );

  clp_ctrl #(
    .DEPTH (DEPTH),
    .KW    (KW),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .in_ready   (s_tready),
    .cmd        (cmd),
    .key        (song_key[KW-1:0]),
    .rd_addr    (rd_addr),
    .rd_key     (rd_key),
    .rd_link    (rd_link),
    .key_we     (key_we),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_valid && res_take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      m_tdata <= {{PAD_BITS{1'b0}}, res.entry_count, res.played_key, res.status};
    end
  end

endmodule

[tb/circular_list_checker.sv]
// ----------------------------------------------------------------------------
// circular_list_checker
// Watches both stream channels of the circular list. Every accepted command
// is run through a local copy of the list (key and link stores, head, tail,
// cursor, entry count). The result this gives is queued. Every accepted result
// is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module circular_list_checker
  import clp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [OUT_TDATA_BITS-1:0] m_tdata,
  output int                        failures,
  output int                        pending,
  output int                        checked,
  output int                        full_hits,
  output int                        miss_hits,
  output int                        empty_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = 64;
  localparam int SLOT_BITS = 6;

  logic [KEY_FIELD_BITS-1:0] key_mem [SLOTS];
  logic [SLOT_BITS-1:0]      link_mem [SLOTS];
  logic                      used [SLOTS];
  logic [SLOT_BITS-1:0]      head_idx;
  logic [SLOT_BITS-1:0]      tail_idx;
  logic [SLOT_BITS-1:0]      cursor_idx;
  int unsigned               entries;
  result_t                   awaited_results [$];

  function automatic result_t apply_command(cmd_t cmd, logic [KEY_FIELD_BITS-1:0] key);
    result_t              r;
    int                   free_slot;
    int                   s;
    int unsigned          i;
    bit                   found;
    logic [SLOT_BITS-1:0] new_slot;
    logic [SLOT_BITS-1:0] cur;
    logic [SLOT_BITS-1:0] prev;
    logic [SLOT_BITS-1:0] succ;
    r.status     = STAT_DONE;
    r.played_key = '0;
    case (cmd)
      CMD_APPEND: begin
        free_slot = -1;
        for (s = 0; s < SLOTS; s++) begin
          if (!used[s] && free_slot < 0) free_slot = s;
        end
        if (entries >= SLOTS || free_slot < 0) begin
          r.status = STAT_FULL;
        end else begin
          new_slot           = SLOT_BITS'(free_slot);
          key_mem[new_slot]  = key;
          used[new_slot]     = 1'b1;
          if (entries == 0) begin
            head_idx   = new_slot;
            tail_idx   = new_slot;
            cursor_idx = new_slot;
          end else begin
            link_mem[tail_idx] = new_slot;
            tail_idx           = new_slot;
          end
          link_mem[new_slot] = head_idx;
          entries++;
        end
      end
      CMD_REMOVE: begin
        if (entries == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          cur   = head_idx;
          prev  = cur;
          found = 1'b0;
          for (i = 0; i < entries && !found; i++) begin
            if (key_mem[cur] == key) begin
              found = 1'b1;
              succ  = link_mem[cur];
              if (entries > 1) begin
                if (i == 0) begin
                  head_idx           = succ;
                  link_mem[tail_idx] = head_idx;
                end else if (cur == tail_idx) begin
                  tail_idx       = prev;
                  link_mem[prev] = head_idx;
                end else begin
                  link_mem[prev] = succ;
                end
              end
              // move the cursor off the unlinked entry
              if (cur == cursor_idx) cursor_idx = succ;
              used[cur] = 1'b0;
              entries--;
            end else begin
              prev = cur;
              cur  = link_mem[cur];
            end
          end
          if (!found) r.status = STAT_NOT_FOUND;
        end
      end
      CMD_PLAY: begin
        if (entries == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.played_key = key_mem[cursor_idx];
          cursor_idx   = link_mem[cursor_idx];
        end
      end
      default: ;
    endcase
    r.entry_count = entries[COUNT_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t                   want;
    status_t                   got_status;
    logic [KEY_FIELD_BITS-1:0] got_key;
    logic [COUNT_BITS-1:0]     got_count;
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        used[s] = 1'b0;
      end
      head_idx   = '0;
      tail_idx   = '0;
      cursor_idx = '0;
      entries    = 0;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got_status = status_t'(m_tdata[1:0]);
        got_key    = m_tdata[33:2];
        got_count  = m_tdata[40:34];
        if (awaited_results.size() == 0) begin
          $error("result item with no command waiting: tdata %h", m_tdata);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          checked++;
          case (want.status)
            STAT_FULL:      full_hits++;
            STAT_NOT_FOUND: miss_hits++;
            STAT_EMPTY:     empty_hits++;
            default: ;
          endcase
          if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            failures++;
          end
          if (got_key !== want.played_key) begin
            $error("played_key: expected %h, got %h", want.played_key, got_key);
            failures++;
          end
          if (got_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got_count);
            failures++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(apply_command(cmd_t'(s_tdata[1:0]), s_tdata[33:2]));
      end
    end
    pending = awaited_results.size();
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives command items into the circular list with play cursor and
// stalls the result channel at random. A short directed opening covers the
// empty, duplicate, cursor and tail cases. Random rounds follow that fill,
// grow, shrink and drain the list with keys from a small shared pool, so
// removes mostly hit. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import clp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 880;
  localparam int CALM_ITEMS     = 150;
  localparam int POOL_SIZE      = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;

  localparam int ROUND_FILL   = 0;
  localparam int ROUND_GROW   = 1;
  localparam int ROUND_SHRINK = 2;
  localparam int ROUND_DRAIN  = 3;

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;

  int failures;
  int pending;
  int checked;
  int full_hits;
  int miss_hits;
  int empty_hits;

  int                        sent;
  int                        quiet_cycles;
  int                        stall_left;
  int                        mode_timer;
  bit                        calm;
  bit                        tx_bursty;
  bit                        rx_bursty;
  logic [KEY_FIELD_BITS-1:0] key_pool [POOL_SIZE];

  always #5 clk = ~clk;

  circular_list_with_play_cursor uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  circular_list_checker list_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .failures   (failures),
    .pending    (pending),
    .checked    (checked),
    .full_hits  (full_hits),
    .miss_hits  (miss_hits),
    .empty_hits (empty_hits)
  );

  task automatic send_command(input cmd_t cmd, input logic [KEY_FIELD_BITS-1:0] key);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, key, cmd};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  function automatic cmd_t draw_command(int append_pct, int remove_pct);
    int r;
    r = $urandom_range(99);
    if (r < append_pct) return CMD_APPEND;
    if (r < append_pct + remove_pct) return CMD_REMOVE;
    if (r < 96) return CMD_PLAY;
    return CMD_NONE;
  endfunction

  function automatic logic [KEY_FIELD_BITS-1:0] draw_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(POOL_SIZE-1)];
  endfunction

  // result side: random stall bursts, switched on and off in stretches
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
      mode_timer = 0;
      rx_bursty  = 1'b1;
    end else begin
      mode_timer++;
      if (mode_timer >= 200) begin
        mode_timer = 0;
        rx_bursty  = $urandom_range(2) != 0;
      end
      if (calm || stall_left == 0) begin
        m_tready <= 1'b1;
        if (!calm && rx_bursty && $urandom_range(7) == 0) stall_left = $urandom_range(1, 15);
      end else begin
        m_tready <= 1'b0;
        stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int   random_sent;
    int   round_no;
    int   round_kind;
    int   round_len;
    int   append_pct;
    int   remove_pct;
    int   n;
    cmd_t cmd;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed opening
    send_command(CMD_PLAY,   32'h0000_0000);
    send_command(CMD_REMOVE, 32'hFFFF_FFFF);
    send_command(CMD_NONE,   32'h0000_0000);
    send_command(CMD_APPEND, 32'h0000_0000);
    send_command(CMD_APPEND, 32'hFFFF_FFFF);
    send_command(CMD_APPEND, 32'h0000_0000);
    send_command(CMD_APPEND, 32'hA5A5_A5A5);
    send_command(CMD_PLAY,   32'h0000_0000);
    send_command(CMD_REMOVE, 32'hFFFF_FFFF);
    send_command(CMD_PLAY,   32'h0000_0000);
    send_command(CMD_REMOVE, 32'h0000_0000);
    send_command(CMD_REMOVE, 32'h1234_5678);
    send_command(CMD_REMOVE, 32'hA5A5_A5A5);
    send_command(CMD_PLAY,   32'hFFFF_FFFF);
    send_command(CMD_NONE,   32'hFFFF_FFFF);
    send_command(CMD_REMOVE, 32'h0000_0000);
    send_command(CMD_PLAY,   32'h0000_0000);
    send_command(CMD_APPEND, 32'h5A5A_5A5A);
    send_command(CMD_PLAY,   32'h0000_0000);
    send_command(CMD_PLAY,   32'h0000_0000);
    send_command(CMD_REMOVE, 32'h5A5A_5A5A);

    // random rounds, starting with one that runs the list past full
    random_sent = 0;
    round_no    = 0;
    while (random_sent < RANDOM_ITEMS) begin
      round_kind = (round_no == 0) ? ROUND_FILL : $urandom_range(ROUND_FILL, ROUND_DRAIN);
      case (round_kind)
        ROUND_FILL:   begin append_pct = 100; remove_pct = 0;  end
        ROUND_GROW:   begin append_pct = 55;  remove_pct = 20; end
        ROUND_SHRINK: begin append_pct = 20;  remove_pct = 55; end
        default:      begin append_pct = 5;   remove_pct = 75; end
      endcase
      round_len = (round_kind == ROUND_FILL) ? 72 : $urandom_range(30, 90);
      tx_bursty = $urandom_range(3) != 0;
      key_pool[$urandom_range(POOL_SIZE-1)] = $urandom;
      for (n = 0; n < round_len && random_sent < RANDOM_ITEMS; n++) begin
        calm = random_sent >= RANDOM_ITEMS - CALM_ITEMS;
        cmd  = draw_command(append_pct, remove_pct);
        send_command(cmd, draw_key());
        random_sent++;
        if (!calm && tx_bursty && $urandom_range(3) == 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
      end
      round_no++;
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run summary: %0d commands in %0d random rounds, %0d results checked",
             sent, round_no, checked);
    $display("run summary: list full %0d, key not found %0d, list empty %0d",
             full_hits, miss_hits, empty_hits);
    if (failures == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[files.f]
hdl/clp_pkg.sv
hdl/clp_store.sv
hdl/clp_ctrl.sv
hdl/circular_list_with_play_cursor.sv
tb/circular_list_checker.sv
tb/testbench.sv
